@@ rtl/lcdsw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdsw_pkg
// Types and constants shared by the segment-LCD serial writer modules.
// ----------------------------------------------------------------------------
package lcdsw_pkg;

	// Frame ID codes, sent MSB first ahead of a command or a data frame.
	localparam logic [2:0] ID_CMD  = 3'b100;
	localparam logic [2:0] ID_DATA = 3'b101;

	localparam int FRAME_W = 17;
	localparam int CNT_W   = 5;

	// Number of bits sent for each kind of item.
	localparam logic [CNT_W-1:0] LEN_CMD       = 5'd12;
	localparam logic [CNT_W-1:0] LEN_DATA_OPEN = 5'd17;
	localparam logic [CNT_W-1:0] LEN_DATA      = 5'd8;

	// Input kinds carried on the slave-side tuser.
	localparam logic FUNC_CMD  = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	// One classified item: bits left aligned, sent from the top down.
	typedef struct packed {
		logic [FRAME_W-1:0] bits;
		logic [CNT_W-1:0]   len;
		logic               frame_end;
	} desc_t;

endpackage

@@ rtl/lcdsw_front.sv @@
// ----------------------------------------------------------------------------
// lcdsw_front
// Accepts input words, tracks whether a data frame is open and builds the
// bit sequence each word will send.
// ----------------------------------------------------------------------------
module lcdsw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // payload[7:0], address[13:8], zeros[15:14]
	input  logic                 s_tuser,   // func
	input  logic                 s_tlast,   // final_byte
	input  logic                 q_full,
	output logic                 push,
	output lcdsw_pkg::desc_t     desc
);

	logic       frame_open_q;
	logic [7:0] payload;
	logic [5:0] address;

	assign payload  = s_tdata[7:0];
	assign address  = s_tdata[13:8];
	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		desc = '0;
		unique case (s_tuser)
			lcdsw_pkg::FUNC_CMD: begin
				// A command closes any open data frame by releasing chip select.
				desc.bits      = {lcdsw_pkg::ID_CMD, payload, 1'b0, 5'b0};
				desc.len       = lcdsw_pkg::LEN_CMD;
				desc.frame_end = 1'b1;
			end
			lcdsw_pkg::FUNC_DATA: begin
				if (frame_open_q) begin
					desc.bits = {payload, 9'b0};
					desc.len  = lcdsw_pkg::LEN_DATA;
				end else begin
					desc.bits = {lcdsw_pkg::ID_DATA, address, payload};
					desc.len  = lcdsw_pkg::LEN_DATA_OPEN;
				end
				desc.frame_end = s_tlast;
			end
			default: desc = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (push) begin
			frame_open_q <= (s_tuser == lcdsw_pkg::FUNC_DATA) && !s_tlast;
		end
	end

endmodule

@@ rtl/lcdsw_queue.sv @@
// ----------------------------------------------------------------------------
// lcdsw_queue
// Two-entry queue of classified items between the front and the serializer.
// ----------------------------------------------------------------------------
module lcdsw_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lcdsw_pkg::desc_t wr_desc,
	output logic             full,
	output logic             q_valid,
	input  logic             pop,
	output lcdsw_pkg::desc_t rd_desc
);

	lcdsw_pkg::desc_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign rd_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/lcdsw_back.sv @@
// ----------------------------------------------------------------------------
// lcdsw_back
// Serializer: shifts each queued item out one bit per output word, MSB first,
// through a registered output stage.
// ----------------------------------------------------------------------------
module lcdsw_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  lcdsw_pkg::desc_t rd_desc,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // serial_bit[0], zeros[7:1]
	output logic             m_tuser,   // frame_end
	output logic             m_tlast    // last
);

	logic [lcdsw_pkg::FRAME_W-1:0] shift_q;
	logic [lcdsw_pkg::CNT_W-1:0]   cnt_q;
	logic                          end_q;
	logic                          out_valid_q;
	logic                          out_bit_q;
	logic                          out_end_q;
	logic                          out_last_q;
	logic                          advance;
	logic                          busy;

	assign advance = !out_valid_q || m_tready;
	assign busy    = (cnt_q != '0);
	assign pop     = advance && !busy && q_valid;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_bit_q};
	assign m_tuser  = out_end_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (busy) begin
				cnt_q       <= cnt_q - 1'b1;
				out_valid_q <= 1'b1;
			end else if (q_valid) begin
				cnt_q       <= rd_desc.len - 1'b1;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Bit and flag registers carry payload only and need no reset.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (busy) begin
				out_bit_q  <= shift_q[lcdsw_pkg::FRAME_W-1];
				shift_q    <= {shift_q[lcdsw_pkg::FRAME_W-2:0], 1'b0};
				out_last_q <= (cnt_q == 5'd1);
				out_end_q  <= end_q && (cnt_q == 5'd1);
			end else if (q_valid) begin
				out_bit_q  <= rd_desc.bits[lcdsw_pkg::FRAME_W-1];
				shift_q    <= {rd_desc.bits[lcdsw_pkg::FRAME_W-2:0], 1'b0};
				end_q      <= rd_desc.frame_end;
				out_last_q <= (rd_desc.len == 5'd1);
				out_end_q  <= rd_desc.frame_end && (rd_desc.len == 5'd1);
			end
		end
	end

endmodule

@@ rtl/lcd_controller_serial_writer.sv @@
// ----------------------------------------------------------------------------
// lcd_controller_serial_writer
// Three-wire segment-LCD write serializer: command and data words in, one
// strobed bit per output word out.
// ----------------------------------------------------------------------------
// A taken word passes through the queue and then the registered output stage.
// Throughput: one output word per cycle while the receiver does not stall; an input
// word sends 12 bits for a command, 17 for a data byte that opens a frame and
// 8 otherwise. Up to two classified words wait in the queue.
// Reset (arst_n low) empties the queue and the shifter and closes any frame.
module lcd_controller_serial_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // payload[7:0], address[13:8], zeros[15:14]
	input  logic        s_tuser,   // func
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // serial_bit[0], zeros[7:1]
	output logic        m_tuser,   // frame_end
	output logic        m_tlast    // last
);

	lcdsw_pkg::desc_t wr_desc;
	lcdsw_pkg::desc_t rd_desc;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_valid;

	lcdsw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.desc     (wr_desc)
	);

	lcdsw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.full    (q_full),
		.q_valid (q_valid),
		.pop     (pop),
		.rd_desc (rd_desc)
	);

	lcdsw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.rd_desc  (rd_desc),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/lcdsw_checker.sv @@
// ----------------------------------------------------------------------------
// lcdsw_checker
// Port-level checks for the serial writer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdsw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	logic [3:0] pending_q;
	logic       in_acc;
	logic       out_done;

	assign in_acc   = s_tvalid && s_tready;
	assign out_done = m_tvalid && m_tready && m_tlast;

	// Words taken in whose final bit has not yet left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {3'b0, in_acc} - {3'b0, out_done};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end on a bit that is not the last of its word");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 4'd0)
		else $error("output bit with no input word outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd4)
		else $error("more words outstanding than the design can hold");

endmodule

bind lcd_controller_serial_writer lcdsw_checker u_lcdsw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ dv/lcd_controller_serial_writer_tb.sv @@
// ----------------------------------------------------------------------------
// lcd_controller_serial_writer_tb
// Self-checking bench for the three-wire LCD write serializer. Command and data
// words are sent in random bursts, and each output word is checked against the
// bit frames predicted from the frame-open state.
// ----------------------------------------------------------------------------
module lcd_controller_serial_writer_tb;

	localparam int TOTAL_ITEMS   = 260;
	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES  = 20;

	typedef struct {
		logic serial_bit;
		logic frame_end;
		logic last;
	} strobe_t;

	// Predicts the strobed bit stream and checks the output words against it.
	class serial_bit_tracker;
		strobe_t     pending_bits[$];
		logic        frame_open;
		int unsigned mismatches;

		function new();
			frame_open = 1'b0;
			mismatches = 0;
		endfunction

		function void push_msb_first(logic [7:0] value, int nbits);
			strobe_t s;
			for (int i = nbits - 1; i >= 0; i--) begin
				s.serial_bit = value[i];
				s.frame_end  = 1'b0;
				s.last       = 1'b0;
				pending_bits.push_back(s);
			end
		endfunction

		function void mark_tail(logic frame_end);
			strobe_t s;
			s = pending_bits.pop_back();
			s.frame_end = frame_end;
			s.last      = 1'b1;
			pending_bits.push_back(s);
		endfunction

		function void note_word(logic func, logic [7:0] payload, logic [5:0] address,
				logic final_byte);
			if (func == lcdsw_pkg::FUNC_CMD) begin
				// A command always closes any open data frame and sends a full frame.
				frame_open = 1'b0;
				push_msb_first({5'b0, lcdsw_pkg::ID_CMD}, 3);
				push_msb_first(payload, 8);
				push_msb_first(8'h00, 1);
				mark_tail(1'b1);
			end else begin
				if (!frame_open) begin
					push_msb_first({5'b0, lcdsw_pkg::ID_DATA}, 3);
					push_msb_first({2'b0, address}, 6);
				end
				push_msb_first(payload, 8);
				mark_tail(final_byte);
				frame_open = !final_byte;
			end
		endfunction

		function void check_bit(logic serial_bit, logic frame_end, logic last);
			strobe_t s;
			if (pending_bits.size() == 0) begin
				$error("unexpected output word: serial_bit=%0b frame_end=%0b last=%0b",
					serial_bit, frame_end, last);
				mismatches++;
			end else begin
				s = pending_bits.pop_front();
				if (serial_bit !== s.serial_bit) begin
					$error("serial_bit: expected %0b, got %0b", s.serial_bit, serial_bit);
					mismatches++;
				end
				if (frame_end !== s.frame_end) begin
					$error("frame_end: expected %0b, got %0b", s.frame_end, frame_end);
					mismatches++;
				end
				if (last !== s.last) begin
					$error("last: expected %0b, got %0b", s.last, last);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return pending_bits.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	serial_bit_tracker tracker;
	int  items_sent;
	int  burst_left;
	int  idle_cycles;
	bit  holdoff_req;

	lcd_controller_serial_writer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one word, with a random gap whenever a burst runs out.
	task automatic send_word(logic func, logic [7:0] payload, logic [5:0] address,
			logic final_byte);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tlast  <= final_byte;
		s_tdata  <= {2'b00, address, payload};
		do @(posedge clk); while (!s_tready);
		tracker.note_word(func, payload, address, final_byte);
		items_sent++;
		burst_left--;
	endtask

	task automatic send_random_frames();
		int pick;
		int nbytes;
		bit holdoff_done;
		holdoff_done = 0;
		while (items_sent < TOTAL_ITEMS) begin
			if (!holdoff_done && items_sent > 60) begin
				holdoff_req  = 1;
				holdoff_done = 1;
			end
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				// Data frame of one to six bytes; only the last byte is marked final.
				nbytes = $urandom_range(1, 6);
				for (int k = 0; k < nbytes; k++)
					send_word(lcdsw_pkg::FUNC_DATA, 8'($urandom_range(0, 255)),
						6'($urandom_range(0, 63)), k == nbytes - 1);
			end else if (pick <= 7) begin
				send_word(lcdsw_pkg::FUNC_CMD, 8'($urandom_range(0, 255)),
					6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end else if (pick == 8) begin
				// Frame left open; whatever comes next continues or cuts it.
				nbytes = $urandom_range(1, 3);
				repeat (nbytes)
					send_word(lcdsw_pkg::FUNC_DATA, 8'($urandom_range(0, 255)),
						6'($urandom_range(0, 63)), 1'b0);
			end else begin
				send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Receiver stall pattern, with one long hold-off on request.
	initial begin
		int mode;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (holdoff_req) begin
				holdoff_req = 0;
				repeat (HOLDOFF_CYCLES) begin
					@(posedge clk);
					m_tready <= 1'b0;
				end
			end
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(10, 80)) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_bit(m_tdata[0], m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** lcd_controller_serial_writer: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		tracker     = new();
		items_sent  = 0;
		burst_left  = 0;
		idle_cycles = 0;
		holdoff_req = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = lcdsw_pkg::FUNC_CMD;
		s_tlast     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, ignored fields, and every frame transition.
		send_word(lcdsw_pkg::FUNC_CMD,  8'h00, 6'h00, 1'b0);
		send_word(lcdsw_pkg::FUNC_CMD,  8'hFF, 6'h3F, 1'b1);
		send_word(lcdsw_pkg::FUNC_DATA, 8'h00, 6'h00, 1'b1);
		send_word(lcdsw_pkg::FUNC_DATA, 8'hFF, 6'h3F, 1'b0);
		send_word(lcdsw_pkg::FUNC_DATA, 8'h5A, 6'h2A, 1'b0);
		send_word(lcdsw_pkg::FUNC_DATA, 8'hA5, 6'h15, 1'b1);
		send_word(lcdsw_pkg::FUNC_DATA, 8'h3C, 6'h15, 1'b0);
		send_word(lcdsw_pkg::FUNC_CMD,  8'h81, 6'h2A, 1'b0);
		send_word(lcdsw_pkg::FUNC_DATA, 8'h80, 6'h3F, 1'b0);
		send_word(lcdsw_pkg::FUNC_DATA, 8'h01, 6'h00, 1'b0);
		send_word(lcdsw_pkg::FUNC_DATA, 8'hFF, 6'h00, 1'b1);
		send_word(lcdsw_pkg::FUNC_CMD,  8'h18, 6'h00, 1'b1);
		send_word(lcdsw_pkg::FUNC_DATA, 8'h7E, 6'h01, 1'b1);
		send_word(lcdsw_pkg::FUNC_DATA, 8'h00, 6'h20, 1'b0);
		send_word(lcdsw_pkg::FUNC_CMD,  8'hFF, 6'h3F, 1'b1);

		send_random_frames();
		s_tvalid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("** lcd_controller_serial_writer: PASSED **");
		else
			$display("** lcd_controller_serial_writer: FAILED **");
		$finish;
	end

endmodule

@@ lcd_controller_serial_writer.f @@
rtl/lcdsw_pkg.sv
rtl/lcdsw_front.sv
rtl/lcdsw_queue.sv
rtl/lcdsw_back.sv
rtl/lcd_controller_serial_writer.sv
rtl/lcdsw_checker.sv
dv/lcd_controller_serial_writer_tb.sv
